// File: hw/rtl/rta_pkg.sv
// Shared types and constants for the region table aligned allocator.
`timescale 1ns / 1ps
`default_nettype none

package rta_pkg;

   localparam int MAX_REGIONS = 16;
   localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

   localparam int ADDR_W      = 64;
   localparam int ENTRY_W     = 2 * ADDR_W;
   localparam int REQ_DATA_W  = 224;
   localparam int RSP_DATA_W  = 32;

   localparam logic [31:0] FLOOR_RESET = 32'h0010_0000;
   localparam logic [32:0] FOUR_GIB    = 33'h1_0000_0000;

   // Item kinds carried on req_tuser.
   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_ALLOC = 2'd2;

   // Result codes carried on rsp_tuser.
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_SKIP = 2'd1;
   localparam logic [1:0] ST_OOM  = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic [ADDR_W-1:0]  start;
      logic [ADDR_W-1:0]  size;
   } rta_wr_type;

   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   idx;
      logic [31:0]        aligned;
      logic [32:0]        need;
      logic [ADDR_W-1:0]  rsize;
   } rta_best_type;

endpackage

`default_nettype wire

// File: hw/rtl/rta_region_store.sv
// Region table memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rta_region_store
   import rta_pkg::*;
(
   input  wire logic               clock,
   input  wire rta_wr_type         wr,
   input  wire logic               rd_en,
   input  wire logic [IDX_W-1:0]   rd_idx,
   output logic [ENTRY_W-1:0]      rd_data_ff
);

   // Each entry holds the region start in the high half and its size in the low half.
   logic [ENTRY_W-1:0] mem [MAX_REGIONS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= {wr.start, wr.size};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/rta_fit_scan.sv
// Fit evaluation pipeline and least-waste tracking over the scanned regions.
`timescale 1ns / 1ps
`default_nettype none

module rta_fit_scan
   import rta_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               issue,
   input  wire logic [IDX_W-1:0]   issue_idx,
   input  wire logic [ENTRY_W-1:0] rd_data,
   input  wire logic [31:0]        align_m1,
   input  wire logic [31:0]        req_size,
   output logic                    busy,
   output rta_best_type            best
);

   logic               p0_valid_ff;
   logic [IDX_W-1:0]   p0_idx_ff;

   logic               p1_valid_ff;
   logic [IDX_W-1:0]   p1_idx_ff;
   logic               p1_base_ok_ff;
   logic [32:0]        p1_base_ff;
   logic [33:0]        p1_aligned_ff;
   logic [ADDR_W-1:0]  p1_rsize_ff;

   logic               p2_valid_ff;
   logic [IDX_W-1:0]   p2_idx_ff;
   logic               p2_cand_ff;
   logic [31:0]        p2_waste_ff;
   logic [31:0]        p2_aligned_ff;
   logic [ADDR_W-1:0]  p2_rsize_ff;

   logic               found_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [31:0]        best_waste_ff;
   logic [31:0]        best_aligned_ff;
   logic [32:0]        best_need_ff;
   logic [ADDR_W-1:0]  best_rsize_ff;

   logic [ADDR_W-1:0]  rd_base;
   logic               base_ok_in;
   logic [33:0]        sum_in;
   logic [33:0]        aligned_in;
   logic [32:0]        end_in;
   logic               cand_in;
   logic [32:0]        need_in;
   logic               fits_in;
   logic               better_in;

   assign rd_base = rd_data[ENTRY_W-1:ADDR_W];

   // Stage one: a start above 4 GiB is never a candidate, so the aligned
   // address only needs enough bits for starts up to 4 GiB.
   always_comb begin
      base_ok_in = (rd_base[ADDR_W-1:33] == '0) &&
                   !(rd_base[32] && (rd_base[31:0] != '0));
      sum_in     = {1'b0, rd_base[32:0]} + {2'b00, align_m1};
      aligned_in = sum_in & {2'b11, ~align_m1};
   end

   // Stage two: range checks; the waste fits in 32 bits once they pass.
   always_comb begin
      end_in  = {1'b0, p1_aligned_ff[31:0]} + {1'b0, req_size};
      cand_in = p1_base_ok_ff &&
                (p1_aligned_ff >= {1'b0, p1_base_ff}) &&
                (p1_aligned_ff[33:32] == 2'b00) &&
                (end_in <= FOUR_GIB);
   end

   // Stage three: size fit and least-waste selection, first index on ties.
   always_comb begin
      need_in   = {1'b0, p2_waste_ff} + {1'b0, req_size};
      fits_in   = {{(ADDR_W-33){1'b0}}, need_in} <= p2_rsize_ff;
      better_in = !found_ff || (best_waste_ff > p2_waste_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         p0_valid_ff <= issue;
         p1_valid_ff <= p0_valid_ff;
         p2_valid_ff <= p1_valid_ff;
         if (start) begin
            found_ff <= 1'b0;
         end else if (p2_valid_ff && p2_cand_ff && fits_in && better_in) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p0_idx_ff     <= issue_idx;
      p1_idx_ff     <= p0_idx_ff;
      p1_base_ok_ff <= base_ok_in;
      p1_base_ff    <= rd_base[32:0];
      p1_aligned_ff <= aligned_in;
      p1_rsize_ff   <= rd_data[ADDR_W-1:0];
      p2_idx_ff     <= p1_idx_ff;
      p2_cand_ff    <= cand_in;
      p2_waste_ff   <= p1_aligned_ff[31:0] - p1_base_ff[31:0];
      p2_aligned_ff <= p1_aligned_ff[31:0];
      p2_rsize_ff   <= p1_rsize_ff;
      if (!start && p2_valid_ff && p2_cand_ff && fits_in && better_in) begin
         best_idx_ff     <= p2_idx_ff;
         best_waste_ff   <= p2_waste_ff;
         best_aligned_ff <= p2_aligned_ff;
         best_need_ff    <= need_in;
         best_rsize_ff   <= p2_rsize_ff;
      end
   end

   assign busy          = p0_valid_ff || p1_valid_ff || p2_valid_ff;
   assign best.found    = found_ff;
   assign best.idx      = best_idx_ff;
   assign best.aligned  = best_aligned_ff;
   assign best.need     = best_need_ff;
   assign best.rsize    = best_rsize_ff;

endmodule

`default_nettype wire

// File: hw/rtl/region_table_aligned_allocator.sv
// Top level of the region table aligned allocator: control, load path and result register.
//
// Items enter on the req_ channel (tuser = mode, tdata = map entry and allocate
// request fields) and each produces exactly one item on the rsp_ channel
// (tdata = address, tuser = status). The placement floor is written on the
// csr_ channel, which is always ready; write it only while no item is in work.
// The region table lives in a 16-entry memory with a registered read.
// Clear and unused modes go straight to the response; a load first computes the
// region end, then makes its decision and writes the entry.
// An allocate reads every stored region once, one per cycle, through a
// three-stage fit pipeline, then writes back the chosen region; with an empty
// table it goes straight to the response.
// One item is in work at a time; req_tready is high whenever the controller is
// idle, even while a finished result still waits in the output register.
// If the receiver stalls, the next result waits in the controller until the
// output register frees, and the input stays closed meanwhile.
// Reset empties the table (count zero), sets the floor to 1 MiB and drops any
// pending result; memory contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module region_table_aligned_allocator
   import rta_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Fields from bit 0: entry_base[63:0], entry_length[63:0], entry_type[31:0],
   // alignment[31:0], request_size[31:0].
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // Fields from bit 0: mode[1:0].
   input  wire logic [1:0]             req_tuser,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // Fields from bit 0: address[31:0].
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   // Fields from bit 0: status[1:0].
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [31:0]            csr_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_LOAD_CHK = 3'd1;
   localparam logic [2:0] S_LOAD_DEC = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_DRAIN    = 3'd4;
   localparam logic [2:0] S_WB       = 3'd5;
   localparam logic [2:0] S_RESP     = 3'd6;

   logic [2:0]         state_ff;
   logic [2:0]         state_in;
   logic [31:0]        floor_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   scan_idx_ff;

   logic [ADDR_W-1:0]  base_ff;
   logic [ADDR_W-1:0]  len_ff;
   logic               type_ok_ff;
   logic [31:0]        align_m1_ff;
   logic [31:0]        size_ff;
   logic [ADDR_W:0]    end_ff;
   logic               below_ff;

   logic [31:0]        res_addr_ff;
   logic [1:0]         res_status_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_addr_ff;
   logic [1:0]         rsp_status_ff;

   logic               req_fire;
   logic               rsp_free;
   logic [ADDR_W-1:0]  floor64;
   logic               keep;
   logic               full;
   logic               scan_last;
   logic               scan_issue;
   logic               scan_start;
   logic               scan_busy;
   logic [31:0]        align_field;
   rta_wr_type         wr;
   rta_best_type       best;
   logic [ENTRY_W-1:0] rd_data;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign floor64    = {{(ADDR_W-32){1'b0}}, floor_ff};
   assign keep       = type_ok_ff && (end_ff[ADDR_W] || (end_ff[ADDR_W-1:0] > floor64));
   assign full       = (count_ff == CNT_W'(MAX_REGIONS));
   assign scan_last  = ((count_ff - CNT_W'(1)) == scan_idx_ff);
   assign scan_issue = (state_ff == S_SCAN);
   assign align_field = req_tdata[191:160];

   // Scan starts when an allocate is accepted with regions in the table.
   assign scan_start = req_fire && (req_tuser == MODE_ALLOC) && (count_ff != '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == MODE_LOAD) begin
                  state_in = S_LOAD_CHK;
               end else if (scan_start) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_LOAD_CHK: state_in = S_LOAD_DEC;
         S_LOAD_DEC: state_in = S_RESP;
         S_SCAN: begin
            if (scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!scan_busy) begin
               state_in = S_WB;
            end
         end
         S_WB: state_in = S_RESP;
         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      wr = '0;
      if (state_ff == S_LOAD_DEC) begin
         wr.en    = keep && !full;
         wr.idx   = count_ff[IDX_W-1:0];
         wr.start = below_ff ? floor64 : base_ff;
         wr.size  = below_ff ? (end_ff[ADDR_W-1:0] - floor64) : len_ff;
      end else if (state_ff == S_WB) begin
         wr.en    = best.found;
         wr.idx   = best.idx;
         wr.start = {{(ADDR_W-32){1'b0}}, best.aligned} + {{(ADDR_W-32){1'b0}}, size_ff};
         wr.size  = best.rsize - {{(ADDR_W-33){1'b0}}, best.need};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         floor_ff     <= FLOOR_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            floor_ff <= csr_data;
         end
         if (req_fire && (req_tuser == MODE_CLEAR)) begin
            count_ff <= '0;
         end else if (wr.en && (state_ff == S_LOAD_DEC)) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if ((state_ff == S_RESP) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         base_ff     <= req_tdata[63:0];
         len_ff      <= req_tdata[127:64];
         type_ok_ff  <= (req_tdata[159:128] == 32'd1);
         align_m1_ff <= (align_field == '0) ? '0 : (align_field - 32'd1);
         size_ff     <= req_tdata[223:192];
         scan_idx_ff <= '0;
         res_addr_ff <= '0;
         case (req_tuser)
            MODE_CLEAR: res_status_ff <= ST_DONE;
            MODE_ALLOC: res_status_ff <= ST_OOM;
            default:    res_status_ff <= ST_SKIP;
         endcase
      end
      if (state_ff == S_LOAD_CHK) begin
         end_ff   <= {1'b0, base_ff} + {1'b0, len_ff};
         below_ff <= base_ff < floor64;
      end
      if (state_ff == S_LOAD_DEC) begin
         res_status_ff <= !keep ? ST_SKIP : (full ? ST_FULL : ST_DONE);
      end
      if (scan_issue) begin
         scan_idx_ff <= scan_idx_ff + CNT_W'(1);
      end
      if ((state_ff == S_WB) && best.found) begin
         res_addr_ff   <= best.aligned;
         res_status_ff <= ST_DONE;
      end
      if ((state_ff == S_RESP) && rsp_free) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

   rta_region_store u_store (
      .clock      (clock),
      .wr         (wr),
      .rd_en      (scan_issue),
      .rd_idx     (scan_idx_ff[IDX_W-1:0]),
      .rd_data_ff (rd_data)
   );

   rta_fit_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .issue     (scan_issue),
      .issue_idx (scan_idx_ff[IDX_W-1:0]),
      .rd_data   (rd_data),
      .align_m1  (align_m1_ff),
      .req_size  (size_ff),
      .busy      (scan_busy),
      .best      (best)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_REGIONS))
      else $error("region count exceeds table depth");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !scan_busy && (state_ff != S_SCAN))
      else $error("table written while a scan reads it");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> ({1'b0, wr.idx} <= count_ff))
      else $error("table write beyond the filled entries");

   a_addr_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_DONE)) |-> (rsp_addr_ff == '0))
      else $error("nonzero address on a failed item");

   a_scan_ends_with_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |-> !scan_busy && $past(state_ff == S_DRAIN))
      else $error("writeback before the fit pipeline drained");

endmodule

`default_nettype wire
